/* rtl/bpa_pkg.sv */
`default_nettype none
// ============================================================================
// bpa_pkg
// Shared types and constants for the bitmap page allocator.
// ============================================================================
package bpa_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_PAGES  = 4096;
    localparam int DEF_PAGE_BYTES = 4096;

    // Field widths fixed by the interface.
    localparam int ADDR_W    = 64;
    localparam int PAGES_W   = 13;
    localparam int BYTES_W   = 25;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 64;

    // The flag store is organised as 64-bit words.
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    // Largest page count that the 13-bit page register can express.
    localparam int PAGES_LIMIT = 8191;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_MEM     = 2'd1,
        ST_MISALIGNED = 2'd2,
        ST_RANGE      = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REGION_BASE  = 8'd0,
        REG_REGION_PAGES = 8'd1
    } t_reg_idx;

    // Result of searching one flag word for a free page.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_pos;
    } t_find;

endpackage
`default_nettype wire

/* rtl/bpa_ifs.sv */
`default_nettype none
// ============================================================================
// bpa_ifs
// Valid/ready channel interfaces: request, response and register write.
// ============================================================================
interface bpa_req_if
    import bpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [ADDR_W-1:0] free_addr;

    modport source (output valid, func, free_addr, input ready);
    modport sink   (input valid, func, free_addr, output ready);
endinterface

interface bpa_rsp_if
    import bpa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  page_addr;
    logic [1:0]         status;
    logic [BYTES_W-1:0] usable_bytes;

    modport source (output valid, page_addr, status, usable_bytes, input ready);
    modport sink   (input valid, page_addr, status, usable_bytes, output ready);
endinterface

interface bpa_cfg_if
    import bpa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/bpa_flag_ram.sv */
`default_nettype none
// ============================================================================
// bpa_flag_ram
// Simple dual-port flag memory: one write port, one registered read port.
// ============================================================================
module bpa_flag_ram
    import bpa_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WORD_BITS-1:0] i_wdata,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/bpa_find_free.sv */
`default_nettype none
// ============================================================================
// bpa_find_free
// Finds the lowest free page in one flag word, ignoring pages past the end.
// ============================================================================
module bpa_find_free
    import bpa_pkg::*;
#(
    parameter int AW = 6
) (
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire logic [AW-1:0]        i_word_idx,
    input  wire logic [PAGES_W-1:0]   i_usable,
    output t_find                     o_find
);

    logic [WORD_BITS-1:0] avail;

    // A page is a candidate when its flag is clear and it lies below the
    // usable page count.
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            avail[b] = !i_word[b] &&
                       (PAGES_W'({i_word_idx, BIT_W'(b)}) < i_usable);
        end
    end

    always_comb begin
        o_find = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                o_find.found   = 1'b1;
                o_find.bit_pos = BIT_W'(b);
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/bitmap_page_allocator.sv */
`default_nettype none
// ============================================================================
// bitmap_page_allocator
// First-fit physical page allocator with one used flag per page.
// ============================================================================
//
//  Channel   Direction  Carries                                  Transfer when
//  i_req     in         func, free_addr                          valid & ready
//  o_rsp     out        page_addr, status, usable_bytes          valid & ready
//  i_cfg     in         index, data (register write)             valid & ready
//
//  An allocate reads flag words through the flag memory's single read port,
//  which delivers one 64-page word per cycle; a free reads one word and
//  writes it back.
//  After reset a clearing pass writes ceil(min(MAX_PAGES, 8191) / 64) words,
//  during which no request is taken; register writes are always taken.
//  The output register lets the next request in while a response waits.
// ============================================================================
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpa_req_if.sink    i_req,
    bpa_rsp_if.source  o_rsp,
    bpa_cfg_if.sink    i_cfg
);

    // The page register is 13 bits wide, so no more flags than that can be
    // addressed, whatever MAX_PAGES says.
    localparam int PAGE_CAP = (MAX_PAGES < PAGES_LIMIT) ? MAX_PAGES : PAGES_LIMIT;
    localparam int WORDS    = (PAGE_CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    // PAGE_BYTES must be a power of two, which the block does not enforce; page arithmetic is shifting.
    localparam int LOG_PB   = $clog2(PAGE_BYTES);

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_PREP    = 9'b000000100,
        S_DECODE  = 9'b000001000,
        S_SCAN    = 9'b000010000,
        S_FREE_RD = 9'b000100000,
        S_FREE_WR = 9'b001000000,
        S_ADDR    = 9'b010000000,
        S_RESULT  = 9'b100000000
    } t_state;

    // Registers and their next values.
    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_base;
    logic [PAGES_W-1:0] r_pages;

    logic [PAGES_W-1:0] r_usable;
    logic [ADDR_W-1:0]  r_first;
    logic [BYTES_W-1:0] r_ubytes;
    logic [AW-1:0]      r_last_word;

    logic               r_func;
    logic [ADDR_W-1:0]  r_addr;
    logic [AW-1:0]      r_clr,      n_clr;
    logic [AW-1:0]      r_rd_word,  n_rd_word;
    logic [PAGES_W-1:0] r_page,     n_page;
    logic [PAGES_W-1:0] r_fidx,     n_fidx;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    t_status            r_res_st,   n_res_st;

    logic               r_o_valid;
    logic [ADDR_W-1:0]  r_o_addr;
    t_status            r_o_st;
    logic [BYTES_W-1:0] r_o_bytes;

    // Combinational terms.
    logic [PAGES_W-1:0]   total;
    logic [PAGES_W-1:0]   reserved;
    logic [PAGES_W-1:0]   usable;
    logic [ADDR_W-1:0]    free_diff;
    logic [ADDR_W-1:0]    free_page;
    logic                 misaligned;
    logic                 out_of_range;
    logic                 in_xfer;
    logic                 out_free;
    logic [AW-1:0]        free_word;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    t_find                find;

    // ------------------------------------------------------------------
    // Register port. Writes to unknown indexes are dropped.
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_pages <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_REGION_BASE:  r_base  <= i_cfg.data;
                REG_REGION_PAGES: r_pages <= i_cfg.data[PAGES_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Region geometry. The leading pages hold the flags, one byte a page,
    // so ceil(total / PAGE_BYTES) of them are held back. These values are
    // registered every cycle; a request passes through S_PREP before it
    // uses them, so a register write just ahead of it is always seen.
    // ------------------------------------------------------------------
    always_comb begin
        total    = (int'(r_pages) > PAGE_CAP) ? PAGES_W'(PAGE_CAP) : r_pages;
        reserved = PAGES_W'((32'(total) + PAGE_BYTES - 1) >> LOG_PB);
        usable   = total - reserved;
    end

    always_ff @(posedge i_clk) begin
        r_usable    <= usable;
        r_first     <= r_base + (ADDR_W'(reserved) << LOG_PB);
        r_ubytes    <= BYTES_W'(ADDR_W'(usable) << LOG_PB);
        r_last_word <= AW'((usable - PAGES_W'(1)) >> BIT_W);
    end

    // ------------------------------------------------------------------
    // Free request checks: alignment first, then the page index relative
    // to the first allocatable page (the subtraction wraps).
    // ------------------------------------------------------------------
    always_comb begin
        misaligned   = |r_addr[LOG_PB-1:0];
        free_diff    = r_addr - r_first;
        free_page    = free_diff >> LOG_PB;
        out_of_range = free_page >= ADDR_W'(r_usable);
        free_word    = AW'(r_fidx >> BIT_W);
    end

    assign in_xfer  = i_req.valid && i_req.ready;
    assign out_free = !r_o_valid || o_rsp.ready;

    // ------------------------------------------------------------------
    // Flag memory and the per-word search.
    // ------------------------------------------------------------------
    bpa_flag_ram #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bpa_find_free #(
        .AW (AW)
    ) u_find (
        .i_word     (ram_rdata),
        .i_word_idx (r_rd_word),
        .i_usable   (r_usable),
        .o_find     (find)
    );

    // ------------------------------------------------------------------
    // Sequencer. An allocate streams flag words through the read port, one
    // a cycle, and checks each word as it returns; a hit issues no further
    // read. The hit word is written back with its bit set in the same cycle.
    // A free reads the word, then writes it back with the bit cleared. Only
    // one request is in flight, so the read-modify-write never overlaps
    // another access to the same word.
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_rd_word  = r_rd_word;
        n_page     = r_page;
        n_fidx     = r_fidx;
        n_res_addr = r_res_addr;
        n_res_st   = r_res_st;
        ram_we     = 1'b0;
        ram_waddr  = r_rd_word;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_rd_word;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DECODE;
            end
            S_DECODE: begin
                n_res_addr = '0;
                n_res_st   = ST_OK;
                if (!r_func) begin
                    if (r_usable == '0) begin
                        n_res_st = ST_NO_MEM;
                        n_state  = S_RESULT;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_rd_word = '0;
                        n_state   = S_SCAN;
                    end
                end else if (misaligned) begin
                    n_res_st = ST_MISALIGNED;
                    n_state  = S_RESULT;
                end else if (out_of_range) begin
                    n_res_st = ST_RANGE;
                    n_state  = S_RESULT;
                end else begin
                    n_fidx  = PAGES_W'(free_page);
                    n_state = S_FREE_RD;
                end
            end
            S_SCAN: begin
                if (find.found) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rd_word;
                    ram_wdata = ram_rdata | (WORD_BITS'(1) << find.bit_pos);
                    n_page    = PAGES_W'({r_rd_word, find.bit_pos});
                    n_state   = S_ADDR;
                end else if (r_rd_word == r_last_word) begin
                    n_res_st = ST_NO_MEM;
                    n_state  = S_RESULT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rd_word + AW'(1);
                    n_rd_word = r_rd_word + AW'(1);
                end
            end
            S_FREE_RD: begin
                ram_re    = 1'b1;
                ram_raddr = free_word;
                n_state   = S_FREE_WR;
            end
            S_FREE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = free_word;
                ram_wdata = ram_rdata & ~(WORD_BITS'(1) << r_fidx[BIT_W-1:0]);
                n_state   = S_RESULT;
            end
            S_ADDR: begin
                n_res_addr = r_first + (ADDR_W'(r_page) << LOG_PB);
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_word  <= n_rd_word;
        r_page     <= n_page;
        r_fidx     <= n_fidx;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
        if (in_xfer) begin
            r_func <= i_req.func;
            r_addr <= i_req.free_addr;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    // ------------------------------------------------------------------
    // Output register. It is loaded when the result is ready and the
    // register is empty or being emptied in the same cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_RESULT && out_free) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT && out_free) begin
            r_o_addr  <= r_res_addr;
            r_o_st    <= r_res_st;
            r_o_bytes <= r_ubytes;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.page_addr    = r_o_addr;
    assign o_rsp.status       = r_o_st;
    assign o_rsp.usable_bytes = r_o_bytes;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("clearing pass re-entered without reset");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (int'(ram_waddr) < WORDS))
        else $error("flag write beyond the memory");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_word <= r_last_word))
        else $error("scan ran past the last usable word");

    a_free_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE_WR) |-> $past(r_state == S_FREE_RD))
        else $error("free write-back without its read");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && out_free) |=> r_o_valid)
        else $error("finished result not presented");

endmodule
`default_nettype wire

/* tb/sv/bitmap_page_allocator_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// bitmap_page_allocator_tb
// Self-checking bench for the first-fit page allocator. A scoreboard keeps
// its own flag array and region registers and predicts every response. It
// then compares each response field by field as it leaves the block. The
// stimulus is a short directed sequence followed by random phases. Each
// phase has its own region setting and its own pattern of idle and stall
// cycles.
// ============================================================================

import bpa_pkg::*;

localparam int          FLAG_PAGES  = DEF_MAX_PAGES;
localparam int          PAGE_BYTES  = DEF_PAGE_BYTES;
localparam logic [63:0] PAGE_STRIDE = 64'(DEF_PAGE_BYTES);

typedef enum bit {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
} t_op;

typedef struct {
    logic [ADDR_W-1:0]  page_addr;
    t_status            status;
    logic [BYTES_W-1:0] usable_bytes;
} t_alloc_result;

class page_alloc_scoreboard;
    logic [ADDR_W-1:0]  region_base  = '0;
    logic [PAGES_W-1:0] region_pages = '0;
    bit                 page_used [FLAG_PAGES];
    t_alloc_result      pending_results [$];
    int                 mismatches   = 0;

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        if (idx == REG_REGION_BASE) begin
            region_base = data;
        end else if (idx == REG_REGION_PAGES) begin
            region_pages = data[PAGES_W-1:0];
        end
    endfunction

    function int total_pages();
        return (region_pages > FLAG_PAGES) ? FLAG_PAGES : int'(region_pages);
    endfunction

    function int reserved_pages();
        return (total_pages() + PAGE_BYTES - 1) / PAGE_BYTES;
    endfunction

    function int usable_pages();
        return total_pages() - reserved_pages();
    endfunction

    // Address of allocatable page idx; wraps modulo 2^64 like the hardware.
    function logic [ADDR_W-1:0] page_address(int idx);
        return region_base + 64'(reserved_pages() + idx) * PAGE_STRIDE;
    endfunction

    function int find_used_page(int start);
        int usable;
        int k;
        int i;
        usable = usable_pages();
        for (k = 0; k < usable; k++) begin
            i = (start + k) % usable;
            if (page_used[i]) return i;
        end
        return -1;
    endfunction

    function void predict_request(bit func, logic [ADDR_W-1:0] addr);
        t_alloc_result r;
        int            usable;
        int            i;
        logic [63:0]   idx;
        usable         = usable_pages();
        r.page_addr    = '0;
        r.status       = ST_OK;
        r.usable_bytes = BYTES_W'(64'(usable) * PAGE_STRIDE);
        if (func == OP_ALLOC) begin
            r.status = ST_NO_MEM;
            for (i = 0; i < usable; i++) begin
                if (!page_used[i]) begin
                    page_used[i] = 1'b1;
                    r.page_addr  = page_address(i);
                    r.status     = ST_OK;
                    break;
                end
            end
        end else if (addr % PAGE_STRIDE != 0) begin
            r.status = ST_MISALIGNED;
        end else begin
            idx = (addr - page_address(0)) / PAGE_STRIDE;
            if (idx >= 64'(usable)) begin
                r.status = ST_RANGE;
            end else begin
                page_used[idx] = 1'b0;
            end
        end
        pending_results.push_back(r);
    endfunction

    function void check_response(logic [ADDR_W-1:0] page_addr, logic [1:0] status,
                                 logic [BYTES_W-1:0] usable_bytes);
        t_alloc_result want;
        if (pending_results.size() == 0) begin
            $error("unexpected response: page_addr %h status %0d usable_bytes %0d",
                   page_addr, status, usable_bytes);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        if (page_addr !== want.page_addr) begin
            $error("page_addr mismatch: expected %h, actual %h", want.page_addr, page_addr);
            mismatches++;
        end
        if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            mismatches++;
        end
        if (usable_bytes !== want.usable_bytes) begin
            $error("usable_bytes mismatch: expected %0d, actual %0d",
                   want.usable_bytes, usable_bytes);
            mismatches++;
        end
    endfunction
endclass

module bitmap_page_allocator_tb;

    // An allocate scans at most 64 flag words, so the tail after the last
    // response is ample for the block to settle.
    localparam int          TAIL_CYCLES   = 80;
    // The slowest legal run is well under 200 us; allow ten times that.
    localparam int unsigned RUN_LIMIT_NS  = 2_000_000;
    localparam int          PHASE_ITEMS   = 50;
    // No register answers to this index, so a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE = 8'hA5;

    logic i_clk;
    logic i_rst_n;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();
    bpa_cfg_if cfg_ch ();

    bitmap_page_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    page_alloc_scoreboard sb = new;

    // Percentages that shape the traffic of the current phase.
    int src_idle_pct  = 0;
    int rsp_stall_pct = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // The response side is always willing or stalling at random. The decision
    // is taken at the falling edge so that it is stable at the next rising edge.
    always @(negedge i_clk) begin
        rsp_ch.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    // Both channels are observed at the rising edge. The response is checked
    // before the request of the same edge is predicted, because a response
    // can never belong to a request that transfers on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                sb.check_response(rsp_ch.page_addr, rsp_ch.status, rsp_ch.usable_bytes);
            end
            if (req_ch.valid && req_ch.ready) begin
                sb.predict_request(req_ch.func, req_ch.free_addr);
            end
        end
    end

    // Present one request from a falling edge and hold it until it transfers.
    // Valid is left high afterwards so that back-to-back requests stay gapless.
    task automatic send_request(t_op op, logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.func      = op;
        req_ch.free_addr = addr;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and let every outstanding response come back.
    task automatic drain_responses();
        req_ch.valid = 1'b0;
        @(negedge i_clk);
        while (sb.pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.write_register(idx, data);
        @(negedge i_clk);
    endtask

    // Registers are only ever rewritten with the block idle.
    task automatic set_region(logic [ADDR_W-1:0] base, int pages);
        drain_responses();
        write_cfg(REG_REGION_BASE, base);
        write_cfg(REG_REGION_PAGES, 64'(pages));
        cfg_ch.valid = 1'b0;
    endtask

    // Mostly well-formed traffic: allocates, and frees of pages known to be
    // in use. The rest are double frees, frees just past the area or of a
    // flag page, and fully random addresses that are nearly always misaligned.
    task automatic random_request();
        int                usable;
        int                pick;
        int                idx;
        int                used;
        t_op               op;
        logic [ADDR_W-1:0] addr;
        usable = sb.usable_pages();
        pick   = $urandom_range(0, 99);
        op     = OP_FREE;
        addr   = {$urandom(), $urandom()};
        if (pick < 50) begin
            op = OP_ALLOC;
        end else if (pick < 88 && usable > 0) begin
            idx = $urandom_range(0, usable - 1);
            if (pick < 80) begin
                used = sb.find_used_page(idx);
                if (used >= 0) idx = used;
            end
            addr = sb.page_address(idx);
        end else if (pick < 94) begin
            if ($urandom_range(0, 1) != 0) begin
                addr = sb.page_address(usable + $urandom_range(0, 15));
            end else begin
                addr = sb.region_base;
            end
        end
        send_request(op, addr);
    endtask

    function automatic logic [ADDR_W-1:0] random_page_base();
        return {$urandom(), $urandom() & 32'hFFFF_F000};
    endfunction

    // One random phase. Halfway through, the sender holds off until every
    // response is back, so that the block also restarts from a fully idle state.
    task automatic run_phase(logic [ADDR_W-1:0] base, int pages, int src_pct, int stall_pct);
        int n;
        set_region(base, pages);
        src_idle_pct  = src_pct;
        rsp_stall_pct = stall_pct;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) drain_responses();
            random_request();
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.func      = OP_ALLOC;
        req_ch.free_addr = '0;
        rsp_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_REGION_BASE;
        cfg_ch.data      = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty region: nothing to allocate, and an aligned free is out of range.
        set_region(64'h0, 0);
        send_request(OP_ALLOC, 64'h0);
        send_request(OP_FREE, 64'h0);
        send_request(OP_FREE, 64'h1);

        // A single page is taken entirely by the flags.
        set_region(64'h0, 1);
        send_request(OP_ALLOC, '1);

        // Three usable pages: fill them, overflow, free, free twice, refill.
        set_region(64'h0000_0001_0000_0000, 4);
        repeat (4) send_request(OP_ALLOC, 64'h0);
        send_request(OP_FREE, sb.page_address(1));
        send_request(OP_FREE, sb.page_address(1));
        send_request(OP_ALLOC, 64'h0);
        send_request(OP_FREE, sb.region_base);
        send_request(OP_FREE, sb.page_address(3));
        send_request(OP_FREE, '1);
        send_request(OP_FREE, 64'h8000_0000_0000_0800);

        // A write to an unknown index must leave the region as it was.
        drain_responses();
        write_cfg(REG_IDX_SPARE, '1);
        cfg_ch.valid = 1'b0;
        send_request(OP_ALLOC, 64'h0);

        // Oversized region at the top of the address space: the area starts
        // after the wrap at address zero, and the old flags are still set.
        set_region(64'hFFFF_FFFF_FFFF_F000, 8191);
        send_request(OP_ALLOC, 64'h0);
        send_request(OP_FREE, sb.page_address(0));
        send_request(OP_ALLOC, 64'h0);
        send_request(OP_FREE, sb.page_address(FLAG_PAGES - 2));
        send_request(OP_FREE, sb.page_address(FLAG_PAGES - 1));
        send_request(OP_FREE, 64'hFFFF_FFFF_FFFF_F000);

        // Random phases cycle through the four traffic patterns.
        run_phase(64'h0, FLAG_PAGES, 0, 0);
        run_phase(random_page_base(), 9, 80, 0);
        run_phase(64'hFFFF_FFFF_FFFF_F000, 8191, 0, 80);
        run_phase({$urandom(), $urandom()}, 2, 26, 26);
        run_phase(random_page_base(), $urandom_range(3, 40), 0, 0);
        run_phase(64'hFFFF_FFFF_FFFF_E000, FLAG_PAGES + 1, 80, 0);
        run_phase(random_page_base(), 65, 0, 80);
        run_phase({$urandom(), $urandom()}, $urandom_range(0, 8191), 26, 26);

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a missing response ends up here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
